@@ src/kstg_pkg.sv @@
// Shared constants and elaboration-time functions for the keyed sine tone generator.
package kstg_pkg;

	localparam int PHASE_BITS_DEF = 32;
	localparam int TABLE_BITS_DEF = 10;

	localparam int AMP_W    = 15;
	localparam int SINE_W   = 15;
	localparam int SAMPLE_W = 16;
	localparam int KEY_W    = 8;
	localparam int NOTE_W   = 4;

	localparam logic [AMP_W-1:0]  AMP_RESET = 15'd10000;
	localparam logic [NOTE_W-1:0] NOTE_NONE = 4'd12;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_KEY  = 1'b1;

	localparam logic [63:0] SAMPLE_RATE_MHZ = 64'd44100000;
	localparam logic [63:0] RESET_FREQ_MHZ  = 64'd130810;
	localparam logic [63:0] PI_Q30          = 64'd3373259426;

	// Maps an ASCII key of either case to a note index, C4 = 0 up to B4 = 11.
	function automatic logic [NOTE_W-1:0] key_note(input logic [KEY_W-1:0] key);
		logic [KEY_W-1:0] k;
		k = key;
		if (k >= 8'h41 && k <= 8'h5A) begin
			k = k + 8'd32;
		end
		case (k)
			8'h61:   return 4'd0;   // a
			8'h77:   return 4'd1;   // w
			8'h73:   return 4'd2;   // s
			8'h65:   return 4'd3;   // e
			8'h64:   return 4'd4;   // d
			8'h66:   return 4'd5;   // f
			8'h72:   return 4'd6;   // r
			8'h6A:   return 4'd7;   // j
			8'h69:   return 4'd8;   // i
			8'h6B:   return 4'd9;   // k
			8'h6F:   return 4'd10;  // o
			8'h6C:   return 4'd11;  // l
			default: return NOTE_NONE;
		endcase
	endfunction

	// Note frequency in millihertz; zero for indexes without a note.
	function automatic logic [63:0] note_mhz(input int note);
		case (note)
			0:       return 64'd261620;
			1:       return 64'd277180;
			2:       return 64'd293660;
			3:       return 64'd311127;
			4:       return 64'd329620;
			5:       return 64'd349220;
			6:       return 64'd370000;
			7:       return 64'd391990;
			8:       return 64'd415300;
			9:       return 64'd440000;
			10:      return 64'd466160;
			11:      return 64'd493880;
			default: return 64'd0;
		endcase
	endfunction

	// Rounded phase increment for a frequency at the sample rate, exact in integers.
	function automatic logic [63:0] incr_for(input logic [63:0] mhz, input int pbits);
		logic [63:0] full;
		logic [63:0] q;
		logic [63:0] r;
		full = 64'd1 << pbits;
		q    = full / SAMPLE_RATE_MHZ;
		r    = full % SAMPLE_RATE_MHZ;
		return mhz * q + (mhz * r + SAMPLE_RATE_MHZ / 2) / SAMPLE_RATE_MHZ;
	endfunction

	// Quarter-wave sine entry in unsigned Q0.15 from a Q2.30 Taylor series.
	// Each term is the previous one times x^2, divided by the next two factorial steps.
	function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] r, input int tbits);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] v;
		x    = (r * PI_Q30) >> (tbits - 1);
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum * 64'sd32768 + (64'sd1 <<< 29)) >>> 30;
		if (v > 64'sd32767) begin
			v = 64'sd32767;
		end
		return v[SINE_W-1:0];
	endfunction

endpackage

@@ src/keyed_sine_tone_generator.sv @@
// Top level of the keyed sine tone generator: handshakes, amplitude register and stages.
//
// Each item on the command channel is either a sample tick (command 0) or a key press
// (command 1). A key press for one of the letters a w s e d f r j i k o l, in either
// case, selects C4 up to B4 and keeps the running phase so the tone stays continuous;
// any other key code selects silence by clearing both the increment and the phase.
// A key press produces no sample. A tick produces one sample, taken at the current
// phase before the phase advances, and the same value appears on left_sample and
// right_sample. The block accepts one item every cycle unless the sample channel stalls.
// A tick's sample passes through registers in order: one, loaded at the edge that takes
// the item, holds the table address, the next the sine magnitude and sign, and the last
// is the output register, where the single amplitude multiply and its rounding finish.
// The whole pipeline advances together, so command items are held off only while a
// finished sample sits in the output register and the sample channel stalls it. After
// reset the amplitude is 10000 and the tone is 130.81 Hz at a 44.1 kHz sample rate.
// The amplitude register should be written only while no tick is in flight.
module keyed_sine_tone_generator #(
	parameter int PHASE_BITS = kstg_pkg::PHASE_BITS_DEF,
	parameter int TABLE_BITS = kstg_pkg::TABLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_we,
	input  logic [kstg_pkg::AMP_W-1:0]    cfg_wdata,

	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic                          command,
	input  logic [kstg_pkg::KEY_W-1:0]    key_code,

	output logic                          smp_valid,
	input  logic                          smp_stall,
	output logic [kstg_pkg::SAMPLE_W-1:0] left_sample,
	output logic [kstg_pkg::SAMPLE_W-1:0] right_sample
);
	import kstg_pkg::*;

	logic                  advance;
	logic                  accept;
	logic [AMP_W-1:0]      amplitude_q;
	logic                  vld_s1;
	logic [TABLE_BITS-1:0] addr_s1;
	logic                  vld_s2;
	logic [SINE_W-1:0]     mag_s2;
	logic                  neg_s2;
	logic [SAMPLE_W-1:0]   sample_q;

	// The pipeline moves unless the output register holds a sample that is not taken.
	assign advance   = !(smp_valid && smp_stall);
	assign cmd_stall = !advance;
	assign accept    = cmd_valid && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= AMP_RESET;
		end else if (cfg_we) begin
			amplitude_q <= cfg_wdata;
		end
	end

	kstg_phase #(
		.PHASE_BITS (PHASE_BITS),
		.TABLE_BITS (TABLE_BITS)
	) u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.accept   (accept),
		.command  (command),
		.key_code (key_code),
		.vld_s1   (vld_s1),
		.addr_s1  (addr_s1)
	);

	kstg_sine #(
		.TABLE_BITS (TABLE_BITS)
	) u_sine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.vld_s1  (vld_s1),
		.addr_s1 (addr_s1),
		.vld_s2  (vld_s2),
		.mag_s2  (mag_s2),
		.neg_s2  (neg_s2)
	);

	kstg_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.amplitude (amplitude_q),
		.vld_s2    (vld_s2),
		.mag_s2    (mag_s2),
		.neg_s2    (neg_s2),
		.vld_q     (smp_valid),
		.sample_q  (sample_q)
	);

	// Both channels carry the same sample.
	assign left_sample  = sample_q;
	assign right_sample = sample_q;

endmodule

@@ src/kstg_phase.sv @@
// Key decode, phase increment and phase accumulator, feeding the table address stage.
module kstg_phase #(
	parameter int PHASE_BITS = kstg_pkg::PHASE_BITS_DEF,
	parameter int TABLE_BITS = kstg_pkg::TABLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        accept,
	input  logic                        command,
	input  logic [kstg_pkg::KEY_W-1:0]  key_code,
	output logic                        vld_s1,
	output logic [TABLE_BITS-1:0]       addr_s1
);
	import kstg_pkg::*;

	localparam int NOTE_SLOTS = 1 << NOTE_W;
	localparam logic [PHASE_BITS-1:0] INC_RESET = PHASE_BITS'(incr_for(RESET_FREQ_MHZ, PHASE_BITS));

	logic [PHASE_BITS-1:0] inc_tab [0:NOTE_SLOTS-1];
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] inc_q;
	logic [NOTE_W-1:0]     note;

	for (genvar n = 0; n < NOTE_SLOTS; n++) begin : g_inc
		assign inc_tab[n] = PHASE_BITS'(incr_for(note_mhz(n), PHASE_BITS));
	end

	assign note = key_note(key_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			inc_q   <= INC_RESET;
		end else if (accept) begin
			if (command == CMD_KEY) begin
				if (note == NOTE_NONE) begin
					inc_q   <= '0;
					phase_q <= '0;
				end else begin
					inc_q <= inc_tab[note];
				end
			end else begin
				phase_q <= phase_q + inc_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= accept && (command == CMD_TICK);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && command == CMD_TICK) begin
			addr_s1 <= phase_q[PHASE_BITS-1 -: TABLE_BITS];
		end
	end

endmodule

@@ src/kstg_sine.sv @@
// Quarter-wave sine table lookup with quadrant mirroring, registered magnitude and sign.
module kstg_sine #(
	parameter int TABLE_BITS = kstg_pkg::TABLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        vld_s1,
	input  logic [TABLE_BITS-1:0]       addr_s1,
	output logic                        vld_s2,
	output logic [kstg_pkg::SINE_W-1:0] mag_s2,
	output logic                        neg_s2
);
	import kstg_pkg::*;

	localparam int QBITS = TABLE_BITS - 2;
	localparam int QSIZE = 1 << QBITS;
	localparam int IDX_W = QBITS + 1;

	logic [SINE_W-1:0] qtab [0:QSIZE];
	logic [1:0]        quad;
	logic [IDX_W-1:0]  r_ext;
	logic [IDX_W-1:0]  idx;

	for (genvar i = 0; i <= QSIZE; i++) begin : g_tab
		assign qtab[i] = quarter_sine(64'(i), TABLE_BITS);
	end

	assign quad  = addr_s1[TABLE_BITS-1 -: 2];
	assign r_ext = {1'b0, addr_s1[QBITS-1:0]};
	// Odd quadrants run the quarter wave backwards.
	assign idx   = quad[0] ? (IDX_W'(QSIZE) - r_ext) : r_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			mag_s2 <= qtab[idx];
			neg_s2 <= quad[1];
		end
	end

endmodule

@@ src/kstg_scale.sv @@
// Amplitude scaling with rounding and the output sample register.
module kstg_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [kstg_pkg::AMP_W-1:0]    amplitude,
	input  logic                          vld_s2,
	input  logic [kstg_pkg::SINE_W-1:0]   mag_s2,
	input  logic                          neg_s2,
	output logic                          vld_q,
	output logic [kstg_pkg::SAMPLE_W-1:0] sample_q
);
	import kstg_pkg::*;

	localparam int PROD_W = AMP_W + SINE_W;

	logic [PROD_W-1:0]   prod;
	logic [PROD_W:0]     rounded;
	logic [SAMPLE_W-1:0] scaled;
	logic [SAMPLE_W-1:0] sample;

	assign prod    = PROD_W'(amplitude) * PROD_W'(mag_s2);
	assign rounded = {1'b0, prod} + (PROD_W + 1)'(1 << (SINE_W - 1));
	assign scaled  = rounded[SINE_W +: SAMPLE_W];
	assign sample  = neg_s2 ? (SAMPLE_W'(0) - scaled) : scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s2) begin
			sample_q <= sample;
		end
	end

endmodule
